>>> hw/rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned KEY_W = 16;
    localparam int unsigned CLS_W = 3;
    localparam int unsigned DUR_W = 16;
    localparam int unsigned OCC_W = 5;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [CLS_W-1:0] entry_class;
        logic [DUR_W-1:0] duration;
    } t_req;

    typedef struct packed {
        logic             out_valid;
        logic [KEY_W-1:0] out_key;
        logic [CLS_W-1:0] out_class;
        logic [DUR_W-1:0] out_duration;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } t_res;

    // one stored slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CLS_W-1:0] entry_class;
        logic [DUR_W-1:0] duration;
    } t_entry;

endpackage

>>> hw/rtl/spq_ram.sv
// generic simple dual-port ram with registered read
module spq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/spq_cmp.sv
// shared key comparator: decides whether a stored slot moves up one place
module spq_cmp (
    input  logic [spq_pkg::KEY_W-1:0] i_new_key,
    input  logic [spq_pkg::KEY_W-1:0] i_slot_key,
    input  logic                      i_at_head,
    output logic                      o_shift
);

    logic w_less;

    // new key strictly below the stored one
    assign w_less = (i_new_key < i_slot_key);

    // the head only yields to a strictly smaller key, other slots also on a tie
    assign o_shift = i_at_head ? w_less : (w_less || (i_new_key == i_slot_key));

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// top level of the sorted priority queue: sequencer, slot ram and key comparator
//
// channel   direction  ports                      transfer
// request   in         i_start, o_busy, i_req     edge with i_start high and o_busy low
// result    out        o_done, o_res              edge ending the cycle o_done is high
//
// pop on an empty queue, insert on a full queue and insert into an empty queue
// are settled in S_IDLE; a pop also passes through S_POP (one ram read of the head)
// an insert scans from the tail toward the head, one slot a cycle through the single
// comparator and the ram read port in S_INS, and passes through S_PUT as well when
// the entry lands at the head
// o_done pulses in the cycle after the last step; a new request may start in that cycle
// reset clears the state, done flag, count and pointers only; the slot ram needs no clearing pass
// the result cannot be stalled: o_done is high for exactly one cycle
module sorted_priority_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  spq_pkg::t_req  i_req,
    output logic           o_done,
    output spq_pkg::t_res  o_res
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = $bits(spq_pkg::t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_POP
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_head, n_head;     // physical slot of the smallest key
    logic [PW-1:0]   r_tail, n_tail;     // physical slot after the largest key
    logic [PW-1:0]   r_ptr, n_ptr;       // slot whose read data is arriving
    spq_pkg::t_entry r_new, n_new;       // entry being inserted
    logic            r_done, n_done;
    spq_pkg::t_res   r_res, n_res;

    // ram ports
    logic            w_we;
    logic [PW-1:0]   w_waddr;
    spq_pkg::t_entry w_wdata;
    logic [PW-1:0]   w_raddr;
    spq_pkg::t_entry w_rdata;
    logic [EW-1:0]   w_rdata_bits;

    logic            w_at_head;
    logic            w_shift;
    logic            w_accept;
    spq_pkg::t_entry w_req_entry;

    // circular pointer steps, depth need not be a power of two
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
    endfunction

    // occupancy field is the count wrapped to its five bits
    function automatic logic [spq_pkg::OCC_W-1:0] occ_of(input logic [CW-1:0] c);
        logic [31:0] wide;
        wide   = 32'(c);
        occ_of = wide[spq_pkg::OCC_W-1:0];
    endfunction

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_rdata  = spq_pkg::t_entry'(w_rdata_bits);
    assign w_at_head = (r_ptr == r_head);

    assign w_req_entry.key         = i_req.key;
    assign w_req_entry.entry_class = i_req.entry_class;
    assign w_req_entry.duration    = i_req.duration;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (EW'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_bits)
    );

    spq_cmp u_cmp (
        .i_new_key  (r_new.key),
        .i_slot_key (w_rdata.key),
        .i_at_head  (w_at_head),
        .o_shift    (w_shift)
    );

    // sequencer next state and ram control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        n_ptr   = r_ptr;
        n_new   = r_new;
        n_done  = 1'b0;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_tail;
        w_wdata = r_new;
        w_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res           = '0;
                    n_res.status    = spq_pkg::ST_OK;
                    n_res.occupancy = occ_of(r_count);
                    n_new           = w_req_entry;
                    if (i_req.req_type == spq_pkg::REQ_POP) begin
                        if (r_count == '0) begin
                            n_res.status = spq_pkg::ST_EMPTY;
                            n_done       = 1'b1;
                        end else begin
                            w_raddr = r_head;
                            n_state = S_POP;
                        end
                    end else begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res.status = spq_pkg::ST_FULL;
                            n_done       = 1'b1;
                        end else if (r_count == '0) begin
                            // first entry goes straight into the tail slot
                            w_we            = 1'b1;
                            w_waddr         = r_tail;
                            w_wdata         = w_req_entry;
                            n_tail          = ptr_inc(r_tail);
                            n_count         = r_count + CW'(1);
                            n_res.occupancy = occ_of(r_count + CW'(1));
                            n_done          = 1'b1;
                        end else begin
                            // start the scan at the last stored entry
                            w_raddr = ptr_dec(r_tail);
                            n_ptr   = ptr_dec(r_tail);
                            n_state = S_INS;
                        end
                    end
                end
            end

            S_INS: begin
                w_we    = 1'b1;
                w_waddr = ptr_inc(r_ptr);
                if (w_shift) begin
                    // move the compared slot up one place
                    w_wdata = w_rdata;
                    if (w_at_head) begin
                        n_state = S_PUT;
                    end else begin
                        w_raddr = ptr_dec(r_ptr);
                        n_ptr   = ptr_dec(r_ptr);
                    end
                end else begin
                    // gap found right above the compared slot
                    w_wdata         = r_new;
                    n_tail          = ptr_inc(r_tail);
                    n_count         = r_count + CW'(1);
                    n_res.occupancy = occ_of(r_count + CW'(1));
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_PUT: begin
                // new entry becomes the head
                w_we            = 1'b1;
                w_waddr         = r_head;
                w_wdata         = r_new;
                n_tail          = ptr_inc(r_tail);
                n_count         = r_count + CW'(1);
                n_res.occupancy = occ_of(r_count + CW'(1));
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end

            S_POP: begin
                n_res.out_valid    = 1'b1;
                n_res.out_key      = w_rdata.key;
                n_res.out_class    = w_rdata.entry_class;
                n_res.out_duration = w_rdata.duration;
                n_res.status       = spq_pkg::ST_OK;
                n_head             = ptr_inc(r_head);
                n_count            = r_count - CW'(1);
                n_res.occupancy    = occ_of(r_count - CW'(1));
                n_done             = 1'b1;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ptr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ptr   <= n_ptr;
            r_done  <= n_done;
        end
        r_new <= n_new;
        r_res <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
